// File: rtl/core/mqtt_packet_parser_assert.svh
// Assertion macros shared by the packet parser RTL.
// Depends on nothing; included by modules that carry concurrent assertions.
`ifndef MQTT_PACKET_PARSER_ASSERT_SVH
`define MQTT_PACKET_PARSER_ASSERT_SVH

// Implication checked at every rising edge, disabled while reset is asserted.
`define MQP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// The consequence must hold in the cycle after the trigger.
`define MQP_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/mqp_pkg.sv
// Types and constants for the MQTT packet parser.
// Depends on nothing; imported by mqtt_packet_parser.
package mqp_pkg;

  typedef enum logic [3:0] {
    PH_HDR     = 4'd0,
    PH_REMLEN  = 4'd1,
    PH_CONNACK = 4'd2,
    PH_SUBACK  = 4'd3,
    PH_SIMPLE  = 4'd4,
    PH_TLEN    = 4'd5,
    PH_TOPIC   = 4'd6,
    PH_PID     = 4'd7,
    PH_PAYLOAD = 4'd8,
    PH_IGNORE  = 4'd9
  } phase_e;

  typedef enum logic [2:0] {
    ROLE_HEADER  = 3'd0,
    ROLE_REMLEN  = 3'd1,
    ROLE_TLEN    = 3'd2,
    ROLE_TOPIC   = 3'd3,
    ROLE_PID     = 3'd4,
    ROLE_PAYLOAD = 3'd5,
    ROLE_ACK     = 3'd6,
    ROLE_IGNORED = 3'd7
  } role_e;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD      = 2'd1;
  localparam logic [1:0] STATUS_NOFIELDS = 2'd2;

  localparam logic [3:0] TYPE_CONNACK  = 4'd2;
  localparam logic [3:0] TYPE_PUBLISH  = 4'd3;
  localparam logic [3:0] TYPE_PUBACK   = 4'd4;
  localparam logic [3:0] TYPE_PUBREC   = 4'd5;
  localparam logic [3:0] TYPE_PUBREL   = 4'd6;
  localparam logic [3:0] TYPE_PUBCOMP  = 4'd7;
  localparam logic [3:0] TYPE_SUBACK   = 4'd9;
  localparam logic [3:0] TYPE_UNSUBACK = 4'd11;

  // A remaining-length field may use at most this many bytes.
  localparam logic [2:0] VARINT_MAX = 3'd4;
  localparam logic [7:0] CODE_NONE  = 8'hFF;

endpackage

// File: rtl/core/mqtt_packet_parser.sv
// Byte-serial parser for received MQTT 3.1.1 control packets.
// Depends on mqp_pkg and mqtt_packet_parser_assert.svh.
//
// Usage:
//   Input channel: one packet byte per transaction on rx_byte_i, with
//   end_of_packet_i high on the final byte. A transaction completes when
//   in_valid_i is high and in_stall_o is low.
//   Output channel: one result per input byte: the byte, its role, and on
//   the final byte (packet_done_o) the packet summary. Summary fields are
//   zero on every other byte. A transaction completes when out_valid_o is
//   high and out_stall_i is low.
//   Each result is registered at the edge that accepts its byte.
//   Throughput: one byte per cycle while in_stall_o is low; the parse
//   phase update and the summary are settled ahead of the result register.
//   Stall: while the result register is full and out_stall_i is high, the
//   result holds and in_stall_o is raised; otherwise a byte is taken every
//   cycle, also while a finished result is being handed over.
//   Reset: rst_ni clears the parse state to "expect fixed header" and
//   empties the result register. After each final byte the parse state
//   returns to the same reset values, ready for the next packet.
module mqtt_packet_parser
  import mqp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        end_of_packet_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  byte_role_o,
  output logic [7:0]  data_out_o,
  output logic        packet_done_o,
  output logic [3:0]  packet_type_o,
  output logic [1:0]  qos_level_o,
  output logic        dup_flag_o,
  output logic        retain_flag_o,
  output logic [15:0] packet_ident_o,
  output logic [7:0]  return_code_o,
  output logic        session_present_o,
  output logic [1:0]  status_o,
  output logic [15:0] topic_length_o
);

  `include "mqtt_packet_parser_assert.svh"

  // Parse state.
  phase_e      phase_q, phase_d;
  logic [3:0]  type_q, type_d;
  logic [3:0]  flags_q, flags_d;
  logic [2:0]  varint_q, varint_d;
  logic [15:0] field_q, field_d;
  logic [15:0] tlen_q, tlen_d;
  logic [15:0] ident_q, ident_d;
  logic [7:0]  code_q, code_d;
  logic        sess_q, sess_d;
  logic [1:0]  stat_q, stat_d;

  // Result register.
  logic        out_valid_q;
  role_e       role_q, role_d;
  logic [7:0]  data_q;
  logic        done_q;
  logic [3:0]  s_type_q, s_type_d;
  logic [1:0]  s_qos_q, s_qos_d;
  logic        s_dup_q, s_dup_d;
  logic        s_ret_q, s_ret_d;
  logic [15:0] s_id_q, s_id_d;
  logic [7:0]  s_code_q, s_code_d;
  logic        s_sess_q, s_sess_d;
  logic [1:0]  s_stat_q, s_stat_d;
  logic [15:0] s_tlen_q, s_tlen_d;

  logic        accept;
  logic [15:0] field_inc;
  logic        qos_nz;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign field_inc  = (field_q != 16'hFFFF) ? field_q + 16'd1 : field_q;
  assign qos_nz     = (flags_q[2:1] != 2'd0);

  // Phase update for the current byte.
  always_comb begin
    phase_d  = phase_q;
    type_d   = type_q;
    flags_d  = flags_q;
    varint_d = varint_q;
    field_d  = field_q;
    tlen_d   = tlen_q;
    ident_d  = ident_q;
    code_d   = code_q;
    sess_d   = sess_q;
    stat_d   = stat_q;
    role_d   = ROLE_IGNORED;
    case (phase_q)
      PH_HDR: begin
        role_d   = ROLE_HEADER;
        type_d   = rx_byte_i[7:4];
        flags_d  = rx_byte_i[3:0];
        varint_d = 3'd0;
        phase_d  = PH_REMLEN;
      end
      PH_REMLEN: begin
        role_d   = ROLE_REMLEN;
        varint_d = varint_q + 3'd1;
        if (!rx_byte_i[7]) begin
          field_d = 16'd0;
          case (type_q)
            TYPE_CONNACK: phase_d = PH_CONNACK;
            TYPE_PUBLISH: phase_d = PH_TLEN;
            TYPE_SUBACK:  phase_d = PH_SUBACK;
            TYPE_PUBACK, TYPE_PUBREC, TYPE_PUBREL, TYPE_PUBCOMP, TYPE_UNSUBACK:
              phase_d = PH_SIMPLE;
            default: phase_d = PH_IGNORE;
          endcase
        end else if (varint_d >= VARINT_MAX) begin
          stat_d  = STATUS_BAD;
          phase_d = PH_IGNORE;
        end
      end
      PH_CONNACK: begin
        if (field_q == 16'd0) begin
          role_d = ROLE_ACK;
          sess_d = (rx_byte_i != 8'd0);
        end else if (field_q == 16'd1) begin
          role_d = ROLE_ACK;
          code_d = rx_byte_i;
        end
        field_d = field_inc;
      end
      PH_SUBACK, PH_SIMPLE: begin
        if (field_q < 16'd2) begin
          role_d  = ROLE_PID;
          ident_d = (field_q == 16'd0) ? {rx_byte_i, 8'h00} : (ident_q | {8'h00, rx_byte_i});
        end else if (field_q == 16'd2 && phase_q == PH_SUBACK) begin
          role_d = ROLE_ACK;
          code_d = rx_byte_i;
        end
        field_d = field_inc;
      end
      PH_TLEN: begin
        role_d = ROLE_TLEN;
        if (field_q == 16'd0) begin
          tlen_d  = {rx_byte_i, 8'h00};
          field_d = 16'd1;
        end else begin
          tlen_d  = tlen_q | {8'h00, rx_byte_i};
          field_d = 16'd0;
          if (tlen_d == 16'd0) begin
            phase_d = qos_nz ? PH_PID : PH_PAYLOAD;
          end else begin
            phase_d = PH_TOPIC;
          end
        end
      end
      PH_TOPIC: begin
        role_d  = ROLE_TOPIC;
        field_d = field_inc;
        if (field_inc >= tlen_q) begin
          field_d = 16'd0;
          phase_d = qos_nz ? PH_PID : PH_PAYLOAD;
        end
      end
      PH_PID: begin
        role_d  = ROLE_PID;
        ident_d = (field_q == 16'd0) ? {rx_byte_i, 8'h00} : (ident_q | {8'h00, rx_byte_i});
        if (field_q == 16'd0) begin
          field_d = 16'd1;
        end else begin
          field_d = 16'd0;
          phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: role_d = ROLE_PAYLOAD;
      default:    role_d = ROLE_IGNORED;
    endcase
  end

  // Packet summary, taken from the state as it stands after this byte.
  always_comb begin
    logic trunc;
    logic nofields;
    trunc    = 1'b0;
    nofields = 1'b0;
    s_id_d   = 16'd0;
    s_code_d = CODE_NONE;
    s_sess_d = 1'b0;
    s_tlen_d = 16'd0;
    case (phase_d)
      PH_HDR, PH_REMLEN, PH_TLEN: trunc = 1'b1;
      PH_CONNACK: begin
        if (field_d >= 16'd2) begin
          s_code_d = code_d;
          s_sess_d = sess_d;
        end else begin
          trunc = 1'b1;
        end
      end
      PH_SUBACK: begin
        if (field_d >= 16'd2) s_id_d = ident_d;
        if (field_d >= 16'd3) s_code_d = code_d;
        else trunc = 1'b1;
      end
      PH_SIMPLE: begin
        if (field_d >= 16'd2) s_id_d = ident_d;
        else trunc = 1'b1;
      end
      PH_TOPIC, PH_PID: begin
        s_tlen_d = tlen_d;
        trunc    = 1'b1;
      end
      PH_PAYLOAD: begin
        s_tlen_d = tlen_d;
        if (flags_d[2:1] != 2'd0) s_id_d = ident_d;
      end
      default: nofields = 1'b1;
    endcase
    s_type_d = type_d;
    if (type_d == TYPE_PUBLISH) begin
      s_qos_d = flags_d[2:1];
      s_dup_d = flags_d[3];
      s_ret_d = flags_d[0];
    end else begin
      s_qos_d = 2'd0;
      s_dup_d = 1'b0;
      s_ret_d = 1'b0;
    end
    if (stat_d == STATUS_BAD || trunc) s_stat_d = STATUS_BAD;
    else if (nofields)                 s_stat_d = STATUS_NOFIELDS;
    else                               s_stat_d = STATUS_OK;
    // Only the final byte carries a summary.
    if (!end_of_packet_i) begin
      s_type_d = 4'd0;
      s_qos_d  = 2'd0;
      s_dup_d  = 1'b0;
      s_ret_d  = 1'b0;
      s_id_d   = 16'd0;
      s_code_d = 8'd0;
      s_sess_d = 1'b0;
      s_stat_d = STATUS_OK;
      s_tlen_d = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR;
      type_q   <= 4'd0;
      flags_q  <= 4'd0;
      varint_q <= 3'd0;
      field_q  <= 16'd0;
      tlen_q   <= 16'd0;
      ident_q  <= 16'd0;
      code_q   <= CODE_NONE;
      sess_q   <= 1'b0;
      stat_q   <= STATUS_OK;
    end else if (accept) begin
      if (end_of_packet_i) begin
        phase_q  <= PH_HDR;
        type_q   <= 4'd0;
        flags_q  <= 4'd0;
        varint_q <= 3'd0;
        field_q  <= 16'd0;
        tlen_q   <= 16'd0;
        ident_q  <= 16'd0;
        code_q   <= CODE_NONE;
        sess_q   <= 1'b0;
        stat_q   <= STATUS_OK;
      end else begin
        phase_q  <= phase_d;
        type_q   <= type_d;
        flags_q  <= flags_d;
        varint_q <= varint_d;
        field_q  <= field_d;
        tlen_q   <= tlen_d;
        ident_q  <= ident_d;
        code_q   <= code_d;
        sess_q   <= sess_d;
        stat_q   <= stat_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      role_q   <= role_d;
      data_q   <= rx_byte_i;
      done_q   <= end_of_packet_i;
      s_type_q <= s_type_d;
      s_qos_q  <= s_qos_d;
      s_dup_q  <= s_dup_d;
      s_ret_q  <= s_ret_d;
      s_id_q   <= s_id_d;
      s_code_q <= s_code_d;
      s_sess_q <= s_sess_d;
      s_stat_q <= s_stat_d;
      s_tlen_q <= s_tlen_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign byte_role_o       = role_q;
  assign data_out_o        = data_q;
  assign packet_done_o     = done_q;
  assign packet_type_o     = s_type_q;
  assign qos_level_o       = s_qos_q;
  assign dup_flag_o        = s_dup_q;
  assign retain_flag_o     = s_ret_q;
  assign packet_ident_o    = s_id_q;
  assign return_code_o     = s_code_q;
  assign session_present_o = s_sess_q;
  assign status_o          = s_stat_q;
  assign topic_length_o    = s_tlen_q;

  `MQP_ASSERT(a_summary_zero, clk_i, rst_ni,
    out_valid_o && !packet_done_o |-> status_o == STATUS_OK && packet_ident_o == 16'd0
      && return_code_o == 8'd0 && topic_length_o == 16'd0 && packet_type_o == 4'd0,
    "summary fields set on a byte that does not end the packet")
  `MQP_ASSERT_NEXT(a_restart, clk_i, rst_ni, accept && end_of_packet_i,
    phase_q == PH_HDR && stat_q == STATUS_OK,
    "parse state not returned to fixed header after the final byte")
  `MQP_ASSERT(a_flags_publish, clk_i, rst_ni,
    out_valid_o && packet_type_o != TYPE_PUBLISH |-> qos_level_o == 2'd0
      && !dup_flag_o && !retain_flag_o,
    "publish flags reported for a packet that is not PUBLISH")
  `MQP_ASSERT_NEXT(a_header_role, clk_i, rst_ni, accept && phase_q == PH_HDR,
    out_valid_o && byte_role_o == ROLE_HEADER,
    "first byte of a packet not tagged as fixed header")

endmodule

// File: tb/mqtt_packet_parser_test.sv
// Self-checking testbench for the byte-serial MQTT packet parser.
// Depends on mqp_pkg and mqtt_packet_parser; a tracking scoreboard predicts every byte's result.
module mqtt_packet_parser_test
  import mqp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] TYPE_RESERVED = 4'hF;
  localparam int RANDOM_BYTES   = 1400;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum int {SHAPE_GOOD, SHAPE_CUT, SHAPE_NOISE} shape_e;

  typedef struct packed {
    role_e       role;
    logic [7:0]  data;
    logic        done;
    logic [3:0]  ptype;
    logic [1:0]  qos;
    logic        dup;
    logic        retain;
    logic [15:0] ident;
    logic [7:0]  code;
    logic        sess;
    logic [1:0]  status;
    logic [15:0] tlen;
  } byte_result_t;

  // Tracks the parse of the current packet and queues the result each byte must produce.
  class parse_tracker;
    phase_e       phase_now;
    logic [3:0]   ptype;
    logic [3:0]   flags;
    logic [2:0]   vcount;
    logic [15:0]  fcount;
    logic [15:0]  tlen_r;
    logic [15:0]  ident_r;
    logic [7:0]   code_r;
    logic         sess_r;
    logic [1:0]   stat_r;
    byte_result_t pending_results[$];
    int           error_count;

    function new();
      clear();
      error_count = 0;
    endfunction

    function void clear();
      phase_now = PH_HDR;
      ptype = '0;
      flags = '0;
      vcount = '0;
      fcount = '0;
      tlen_r = '0;
      ident_r = '0;
      code_r = CODE_NONE;
      sess_r = 1'b0;
      stat_r = STATUS_OK;
    endfunction

    function void bump();
      if (fcount != 16'hFFFF) fcount = fcount + 16'd1;
    endfunction

    function void start_after_topic();
      fcount = '0;
      phase_now = (flags[2:1] != 2'd0) ? PH_PID : PH_PAYLOAD;
    endfunction

    function void merge_ident(logic [7:0] b, logic first);
      if (first) ident_r = {b, 8'h00};
      else ident_r = ident_r | {8'h00, b};
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      byte_result_t r;
      role_e        role;
      logic [15:0]  id;
      logic [7:0]   code;
      logic         sess;
      logic [15:0]  tl;
      logic         bad;
      logic         nofld;
      role = ROLE_IGNORED;
      case (phase_now)
        PH_HDR: begin
          role = ROLE_HEADER;
          ptype = b[7:4];
          flags = b[3:0];
          vcount = '0;
          phase_now = PH_REMLEN;
        end
        PH_REMLEN: begin
          role = ROLE_REMLEN;
          vcount = vcount + 3'd1;
          if (!b[7]) begin
            fcount = '0;
            case (ptype)
              TYPE_CONNACK: phase_now = PH_CONNACK;
              TYPE_PUBLISH: phase_now = PH_TLEN;
              TYPE_SUBACK: phase_now = PH_SUBACK;
              TYPE_PUBACK, TYPE_PUBREC, TYPE_PUBREL, TYPE_PUBCOMP, TYPE_UNSUBACK:
                phase_now = PH_SIMPLE;
              default: phase_now = PH_IGNORE;
            endcase
          end else if (vcount >= VARINT_MAX) begin
            stat_r = STATUS_BAD;
            phase_now = PH_IGNORE;
          end
        end
        PH_CONNACK: begin
          if (fcount == 16'd0) begin
            role = ROLE_ACK;
            sess_r = (b != 8'h00);
          end else if (fcount == 16'd1) begin
            role = ROLE_ACK;
            code_r = b;
          end
          bump();
        end
        PH_SUBACK: begin
          if (fcount < 16'd2) begin
            role = ROLE_PID;
            merge_ident(b, fcount == 16'd0);
          end else if (fcount == 16'd2) begin
            role = ROLE_ACK;
            code_r = b;
          end
          bump();
        end
        PH_SIMPLE: begin
          if (fcount < 16'd2) begin
            role = ROLE_PID;
            merge_ident(b, fcount == 16'd0);
          end
          bump();
        end
        PH_TLEN: begin
          role = ROLE_TLEN;
          if (fcount == 16'd0) begin
            tlen_r = {b, 8'h00};
            fcount = 16'd1;
          end else begin
            tlen_r = tlen_r | {8'h00, b};
            if (tlen_r == 16'd0) begin
              start_after_topic();
            end else begin
              fcount = '0;
              phase_now = PH_TOPIC;
            end
          end
        end
        PH_TOPIC: begin
          role = ROLE_TOPIC;
          bump();
          if (fcount >= tlen_r) start_after_topic();
        end
        PH_PID: begin
          role = ROLE_PID;
          merge_ident(b, fcount == 16'd0);
          if (fcount == 16'd0) begin
            fcount = 16'd1;
          end else begin
            fcount = '0;
            phase_now = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: role = ROLE_PAYLOAD;
        default: role = ROLE_IGNORED;
      endcase

      r = '0;
      r.role = role;
      r.data = b;
      r.done = last;
      if (last) begin
        id = '0;
        code = CODE_NONE;
        sess = 1'b0;
        tl = '0;
        bad = 1'b0;
        nofld = 1'b0;
        case (phase_now)
          PH_HDR, PH_REMLEN, PH_TLEN: bad = 1'b1;
          PH_CONNACK: begin
            if (fcount >= 16'd2) begin
              code = code_r;
              sess = sess_r;
            end else begin
              bad = 1'b1;
            end
          end
          PH_SUBACK: begin
            if (fcount >= 16'd2) id = ident_r;
            if (fcount >= 16'd3) code = code_r;
            else bad = 1'b1;
          end
          PH_SIMPLE: begin
            if (fcount >= 16'd2) id = ident_r;
            else bad = 1'b1;
          end
          PH_TOPIC, PH_PID: begin
            tl = tlen_r;
            bad = 1'b1;
          end
          PH_PAYLOAD: begin
            tl = tlen_r;
            if (flags[2:1] != 2'd0) id = ident_r;
          end
          default: nofld = 1'b1;
        endcase
        r.ptype = ptype;
        if (ptype == TYPE_PUBLISH) begin
          r.qos = flags[2:1];
          r.dup = flags[3];
          r.retain = flags[0];
        end
        r.ident = id;
        r.code = code;
        r.sess = sess;
        if (stat_r == STATUS_BAD || bad) r.status = STATUS_BAD;
        else if (nofld) r.status = STATUS_NOFIELDS;
        else r.status = STATUS_OK;
        r.tlen = tl;
        clear();
      end
      pending_results.insert(pending_results.size(), r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        error_count++;
      end
    endfunction

    function void check_result(byte_result_t got);
      byte_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual data %0h",
                 $time, got.data);
        error_count++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("byte_role", want.role, got.role);
      compare_field("data_out", want.data, got.data);
      compare_field("packet_done", want.done, got.done);
      compare_field("packet_type", want.ptype, got.ptype);
      compare_field("qos_level", want.qos, got.qos);
      compare_field("dup_flag", want.dup, got.dup);
      compare_field("retain_flag", want.retain, got.retain);
      compare_field("packet_ident", want.ident, got.ident);
      compare_field("return_code", want.code, got.code);
      compare_field("session_present", want.sess, got.sess);
      compare_field("status", want.status, got.status);
      compare_field("topic_length", want.tlen, got.tlen);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i;
  logic        end_of_packet_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  byte_role_o;
  logic [7:0]  data_out_o;
  logic        packet_done_o;
  logic [3:0]  packet_type_o;
  logic [1:0]  qos_level_o;
  logic        dup_flag_o;
  logic        retain_flag_o;
  logic [15:0] packet_ident_o;
  logic [7:0]  return_code_o;
  logic        session_present_o;
  logic [1:0]  status_o;
  logic [15:0] topic_length_o;

  parse_tracker tracker;
  logic [7:0]   pkt[$];
  int           burst_left = 0;
  int           bytes_sent = 0;
  int           idle_cycles = 0;
  int           stall_cycle = 0;

  mqtt_packet_parser dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .rx_byte_i         (rx_byte_i),
    .end_of_packet_i   (end_of_packet_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .byte_role_o       (byte_role_o),
    .data_out_o        (data_out_o),
    .packet_done_o     (packet_done_o),
    .packet_type_o     (packet_type_o),
    .qos_level_o       (qos_level_o),
    .dup_flag_o        (dup_flag_o),
    .retain_flag_o     (retain_flag_o),
    .packet_ident_o    (packet_ident_o),
    .return_code_o     (return_code_o),
    .session_present_o (session_present_o),
    .status_o          (status_o),
    .topic_length_o    (topic_length_o)
  );

  always #5 clk_i = ~clk_i;

  // The receiver cycles through free-flowing, light, heavy and periodic stalling.
  always @(posedge clk_i) begin
    stall_cycle <= stall_cycle + 1;
    case (stall_cycle[9:8])
      2'd0: out_stall_i <= 1'b0;
      2'd1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall_i <= ($urandom_range(0, 9) < 7);
      default: out_stall_i <= stall_cycle[2] & stall_cycle[0];
    endcase
  end

  always @(posedge clk_i) begin
    byte_result_t seen;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.role = role_e'(byte_role_o);
      seen.data = data_out_o;
      seen.done = packet_done_o;
      seen.ptype = packet_type_o;
      seen.qos = qos_level_o;
      seen.dup = dup_flag_o;
      seen.retain = retain_flag_o;
      seen.ident = packet_ident_o;
      seen.code = return_code_o;
      seen.sess = session_present_o;
      seen.status = status_o;
      seen.tlen = topic_length_o;
      tracker.check_result(seen);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("mqtt_packet_parser test failed");
        $finish;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 40);
    end
    rx_byte_i <= b;
    end_of_packet_i <= last;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_byte(b, last);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt.size(); i++) push_byte(pkt[i], i == pkt.size() - 1);
  endtask

  // Holds the input off until every predicted result has been handed over.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (tracker.pending_results.size() != 0);
  endtask

  function automatic void add_byte(logic [7:0] b);
    pkt.insert(pkt.size(), b);
  endfunction

  function automatic void build_packet(shape_e shape);
    logic [3:0]  kind;
    logic [7:0]  hdr;
    logic [15:0] tl;
    int          n;
    int          cut;
    pkt.delete();
    if (shape == SHAPE_NOISE) begin
      n = $urandom_range(1, 8);
      repeat (n) add_byte(8'($urandom_range(0, 255)));
      return;
    end
    case ($urandom_range(0, 9))
      0: kind = TYPE_CONNACK;
      1: kind = TYPE_SUBACK;
      2, 3, 4: kind = TYPE_PUBLISH;
      5: kind = 4'($urandom_range(TYPE_PUBACK, TYPE_PUBCOMP));
      6: kind = TYPE_UNSUBACK;
      default: kind = 4'($urandom_range(0, 15));
    endcase
    hdr = {kind, 4'($urandom_range(0, 15))};
    add_byte(hdr);

    // Four continuation bytes in a row make the length field malformed.
    if (shape == SHAPE_CUT && $urandom_range(0, 3) == 0) begin
      repeat (4) add_byte(8'h80 | 8'($urandom_range(0, 127)));
    end else begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
      for (int i = 0; i < n; i++)
        add_byte({i != n - 1, 7'($urandom_range(0, 127))});
    end

    case (kind)
      TYPE_CONNACK: begin
        add_byte($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255)));
        add_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) == 0) add_byte(8'($urandom_range(0, 255)));
      end
      TYPE_SUBACK: begin
        n = $urandom_range(3, 5);
        repeat (n) add_byte(8'($urandom_range(0, 255)));
      end
      TYPE_PUBACK, TYPE_PUBREC, TYPE_PUBREL, TYPE_PUBCOMP, TYPE_UNSUBACK: begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 4) : 2;
        repeat (n) add_byte(8'($urandom_range(0, 255)));
      end
      TYPE_PUBLISH: begin
        case ($urandom_range(0, 19))
          0: tl = 16'd0;
          1: tl = 16'($urandom_range(256, 300));
          default: tl = 16'($urandom_range(1, 6));
        endcase
        if (shape == SHAPE_CUT && $urandom_range(0, 1)) tl = 16'($urandom_range(0, 65535));
        add_byte(tl[15:8]);
        add_byte(tl[7:0]);
        // A cut packet never reaches the end of a huge topic anyway.
        n = (shape == SHAPE_CUT && tl > 16'd12) ? 12 : int'(tl);
        repeat (n) add_byte(8'($urandom_range(0, 255)));
        if (hdr[2:1] != 2'd0) repeat (2) add_byte(8'($urandom_range(0, 255)));
        n = $urandom_range(0, 8);
        repeat (n) add_byte(8'($urandom_range(0, 255)));
      end
      default: begin
        n = $urandom_range(0, 4);
        repeat (n) add_byte(8'($urandom_range(0, 255)));
      end
    endcase

    if (shape == SHAPE_CUT) begin
      cut = $urandom_range(1, pkt.size());
      while (pkt.size() > cut) void'(pkt.pop_back());
    end
  endfunction

  initial begin
    int pick;
    tracker = new();
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    rx_byte_i <= 8'h00;
    end_of_packet_i <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Packet cut off right after the fixed header.
    pkt = '{{TYPE_CONNACK, 4'h0}};
    send_packet();
    // Remaining length runs past four bytes; the rest is ignored.
    pkt = '{{TYPE_PUBLISH, 4'h0}, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h00};
    send_packet();
    pkt = '{{TYPE_CONNACK, 4'h0}, 8'h02, 8'h01, 8'h00};
    send_packet();
    // Empty topic, qos 3 with dup and retain, all-ones identifier.
    pkt = '{{TYPE_PUBLISH, 4'hF}, 8'h07, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h5A};
    send_packet();
    // Ends halfway through the packet identifier.
    pkt = '{{TYPE_PUBLISH, 4'h2}, 8'h05, 8'h00, 8'h01, 8'h61, 8'h12};
    send_packet();
    pkt = '{{TYPE_RESERVED, 4'h0}, 8'h00};
    send_packet();
    drain_results();

    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) build_packet(SHAPE_GOOD);
      else if (pick < 93) build_packet(SHAPE_CUT);
      else build_packet(SHAPE_NOISE);
      send_packet();
      if ($urandom_range(0, 29) == 0) drain_results();
    end

    drain_results();
    repeat (4) @(posedge clk_i);
    if (tracker.error_count == 0 && tracker.pending_results.size() == 0)
      $display("mqtt_packet_parser test passed");
    else
      $display("mqtt_packet_parser test failed");
    $finish;
  end

endmodule
